FILE: sv/tkpq_pkg.sv
// Shared types, constants and address helpers for the two-key priority queue.
// No dependencies; every other file of the block but tkpq_ram imports this package.
package tkpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int KEY_W       = 48;
   localparam int PAY_W       = 28;
   localparam int ENTRY_W     = KEY_W + PAY_W;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // key is {turn_time, tie_order}; payload is {heading, glyph, y, x}
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] pay;
   } entry_type;

   typedef struct packed {
      logic      start;
      op_type    op;
      entry_type entry;
   } cmd_type;

   typedef struct packed {
      logic       done;
      status_type status;
      logic       valid;
      entry_type  entry;
      count_type  count;
   } result_type;

   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      entry_type wr_data;
      logic      rd_en;
      addr_type  rd_addr;
   } mem_req_type;

   // Ring address: base plus offset, wrapped at the queue depth.
   function automatic addr_type wrap_add(addr_type base, addr_type offset);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

FILE: sv/tkpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tkpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tkpq_seq.sv
// Queue sequencer: ring pointers, entry count, head shadow and the insert walk.
// Depends on tkpq_pkg; drives the entry RAM through a request struct.
module tkpq_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  tkpq_pkg::cmd_type         cmd,
   input  tkpq_pkg::entry_type       rd_data,
   output tkpq_pkg::mem_req_type     mem_req,
   output tkpq_pkg::result_type      result,
   output logic                      busy
);
   import tkpq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_PLACE = 4'b0100,
      S_HEAD  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   addr_type  base_ff, base_in;
   addr_type  idx_ff, idx_in;
   entry_type head_ff, head_in;
   entry_type new_ff, new_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      head_in  = head_ff;
      new_in   = new_ff;
      mem_req  = '0;
      result   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == OP_POP) begin
                  result.done = 1'b1;
                  if (count_ff == '0) begin
                     result.status = ST_EMPTY;
                     result.count  = count_ff;
                  end else begin
                     // report the head, advance the ring base
                     result.status = ST_OK;
                     result.valid  = 1'b1;
                     result.entry  = head_ff;
                     result.count  = count_ff - count_type'(1);
                     count_in      = count_ff - count_type'(1);
                     base_in       = wrap_add(base_ff, addr_type'(1));
                     if (count_ff > count_type'(1)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = wrap_add(base_ff, addr_type'(1));
                        state_in        = S_HEAD;
                     end
                  end
               end else if (count_ff == count_type'(QUEUE_DEPTH)) begin
                  // drop the push
                  result.done   = 1'b1;
                  result.status = ST_FULL;
                  result.valid  = 1'b1;
                  result.entry  = head_ff;
                  result.count  = count_ff;
               end else begin
                  new_in = cmd.entry;
                  if (count_ff == '0) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = base_ff;
                     mem_req.wr_data = cmd.entry;
                     head_in         = cmd.entry;
                     count_in        = count_type'(1);
                     result.done     = 1'b1;
                     result.status   = ST_OK;
                     result.valid    = 1'b1;
                     result.entry    = cmd.entry;
                     result.count    = count_type'(1);
                  end else begin
                     // start the walk at the tail
                     idx_in          = count_ff[ADDR_W-1:0];
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = wrap_add(base_ff,
                                                count_ff[ADDR_W-1:0] - addr_type'(1));
                     state_in        = S_WALK;
                  end
               end
            end
         end

         S_WALK: begin
            // rd_data holds slot idx-1
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wrap_add(base_ff, idx_ff);
            if (rd_data.key > new_ff.key) begin
               mem_req.wr_data = rd_data;
               if (idx_ff == addr_type'(1)) begin
                  idx_in   = '0;
                  state_in = S_PLACE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = wrap_add(base_ff, idx_ff - addr_type'(2));
                  idx_in          = idx_ff - addr_type'(1);
               end
            end else begin
               mem_req.wr_data = new_ff;
               count_in        = count_ff + count_type'(1);
               result.done     = 1'b1;
               result.status   = ST_OK;
               result.valid    = 1'b1;
               result.entry    = head_ff;
               result.count    = count_ff + count_type'(1);
               state_in        = S_IDLE;
            end
         end

         S_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = base_ff;
            mem_req.wr_data = new_ff;
            head_in         = new_ff;
            count_in        = count_ff + count_type'(1);
            result.done     = 1'b1;
            result.status   = ST_OK;
            result.valid    = 1'b1;
            result.entry    = new_ff;
            result.count    = count_ff + count_type'(1);
            state_in        = S_IDLE;
         end

         S_HEAD: begin
            head_in  = rd_data;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         base_ff  <= base_in;
      end
      idx_ff  <= idx_in;
      head_ff <= head_in;
      new_ff  <= new_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: sv/two_key_priority_queue_core.sv
// Top level of the two-key priority queue: request packing, result register,
// entry RAM. Depends on tkpq_pkg, tkpq_ram and tkpq_seq.
//
// A bounded priority queue of up to QUEUE_DEPTH entries, kept sorted by
// {turn_time, tie_order}, smallest first; among equal keys a newer entry goes
// after the older ones. Raise start with the request ports valid; the item is
// taken at the edge where start is high and busy is low. Each item gives one
// result, shown for exactly one cycle with rsp_valid high, in the cycle after
// the work ends; the receiver cannot stall it, so sample on rsp_valid. A pop
// answers from the head shadow and, when entries remain, stays busy to fetch
// the next head. A push to an empty or full queue finishes from idle. Any other
// push walks from the tail toward the head, one entry a cycle, through the
// single-port-read entry RAM: it fetches the tail, shifts each stored entry
// with a larger key up one slot, then places the new entry. The entries live
// in a ring in RAM, so a pop moves the base pointer and shifts no entry. No
// clearing pass is needed after reset.
module two_key_priority_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [7:0]                  req_x_pos,
   input  logic [7:0]                  req_y_pos,
   input  logic [31:0]                 req_turn_time,
   input  logic [15:0]                 req_tie_order,
   input  logic [7:0]                  req_glyph,
   input  logic signed [3:0]           req_heading,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_entry_valid,
   output logic [7:0]                  rsp_entry_x,
   output logic [7:0]                  rsp_entry_y,
   output logic [31:0]                 rsp_entry_turn,
   output logic [15:0]                 rsp_entry_tie,
   output logic [7:0]                  rsp_entry_glyph,
   output logic signed [3:0]           rsp_entry_heading,
   output logic [tkpq_pkg::CNT_W-1:0]  rsp_entry_count,
   output logic                        rsp_queue_empty
);
   import tkpq_pkg::*;

   cmd_type     cmd;
   mem_req_type mem_req;
   result_type  result;
   entry_type   rd_data;
   logic        seq_busy;

   // result register: strobe is control, the rest is payload
   logic       rsp_valid_ff;
   result_type rsp_ff;

   // pack the request: key {turn, tie}, payload {heading, glyph, y, x}
   always_comb begin
      cmd.start     = start & ~seq_busy;
      cmd.op        = op_type'(req_opcode);
      cmd.entry.key = {req_turn_time, req_tie_order};
      cmd.entry.pay = {req_heading, req_glyph, req_y_pos, req_x_pos};
   end

   tkpq_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .mem_req (mem_req),
      .result  (result),
      .busy    (seq_busy)
   );

   tkpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // hold the result for its one strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result.done;
      end
      if (result.done) begin
         rsp_ff <= result;
      end
   end

   assign busy              = seq_busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_entry_valid   = rsp_ff.valid;
   assign rsp_entry_x       = rsp_ff.entry.pay[7:0];
   assign rsp_entry_y       = rsp_ff.entry.pay[15:8];
   assign rsp_entry_glyph   = rsp_ff.entry.pay[23:16];
   assign rsp_entry_heading = rsp_ff.entry.pay[27:24];
   assign rsp_entry_turn    = rsp_ff.entry.key[47:16];
   assign rsp_entry_tie     = rsp_ff.entry.key[15:0];
   assign rsp_entry_count   = rsp_ff.count;
   assign rsp_queue_empty   = (rsp_ff.count == '0);

endmodule

FILE: bench/tb_two_key_priority_queue_core.sv
`timescale 1ns / 1ps
// Self-checking bench for two_key_priority_queue_core: directed and random push/pop items,
// each result checked against a shadow sorted list. Depends on tkpq_pkg and the core RTL.
module tb_two_key_priority_queue_core;
   import tkpq_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int PHASE_ITEMS  = 210;
   localparam int BIAS_SPAN    = 40;

   // One result as it leaves the core, fields at port widths.
   typedef struct packed {
      status_type       status;
      logic             valid;
      logic [7:0]       x;
      logic [7:0]       y;
      logic [31:0]      turn;
      logic [15:0]      tie;
      logic [7:0]       glyph;
      logic [3:0]       heading;
      logic [CNT_W-1:0] count;
      logic             is_empty;
   } reply_type;

   // Shadow of the queue contents plus the replies it still owes.
   class turn_queue_shadow;
      logic [KEY_W-1:0] keys [QUEUE_DEPTH];
      logic [PAY_W-1:0] pays [QUEUE_DEPTH];
      int               fill;
      reply_type        pending_replies [$];
      int               mismatches;
      int               pushes;
      int               pops;
      int               full_drops;
      int               empty_pops;
      int               deepest;

      function new();
         fill       = 0;
         mismatches = 0;
         pushes     = 0;
         pops       = 0;
         full_drops = 0;
         empty_pops = 0;
         deepest    = 0;
      endfunction

      function reply_type entry_reply(logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
         reply_type r;
         r         = '0;
         r.status  = ST_OK;
         r.valid   = 1'b1;
         r.turn    = key[47:16];
         r.tie     = key[15:0];
         r.x       = pay[7:0];
         r.y       = pay[15:8];
         r.glyph   = pay[23:16];
         r.heading = pay[27:24];
         return r;
      endfunction

      // Apply one accepted item and queue the reply it must produce.
      function void note_command(op_type op, entry_type e);
         reply_type r;
         int        slot;
         int        i;
         if (op == OP_PUSH) begin
            pushes++;
            if (fill >= QUEUE_DEPTH) begin
               full_drops++;
               r        = entry_reply(keys[0], pays[0]);
               r.status = ST_FULL;
            end else begin
               // land after every entry with a key less than or equal
               slot = 0;
               while (slot < fill && keys[slot] <= e.key) slot++;
               for (i = fill; i > slot; i--) begin
                  keys[i] = keys[i-1];
                  pays[i] = pays[i-1];
               end
               keys[slot] = e.key;
               pays[slot] = e.pay;
               fill++;
               if (fill > deepest) deepest = fill;
               r = entry_reply(keys[0], pays[0]);
            end
         end else begin
            pops++;
            if (fill == 0) begin
               empty_pops++;
               r        = '0;
               r.status = ST_EMPTY;
            end else begin
               r = entry_reply(keys[0], pays[0]);
               for (i = 1; i < fill; i++) begin
                  keys[i-1] = keys[i];
                  pays[i-1] = pays[i];
               end
               fill--;
            end
         end
         r.count    = CNT_W'(fill);
         r.is_empty = (fill == 0);
         pending_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            mismatches++;
         end
      endfunction

      // Check one result against the oldest reply owed.
      function void check_reply(reply_type seen);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: result with nothing pending, actual %h", $time, seen);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         compare_field("status", want.status, seen.status);
         compare_field("entry_valid", want.valid, seen.valid);
         compare_field("entry_x", want.x, seen.x);
         compare_field("entry_y", want.y, seen.y);
         compare_field("entry_turn", want.turn, seen.turn);
         compare_field("entry_tie", want.tie, seen.tie);
         compare_field("entry_glyph", want.glyph, seen.glyph);
         compare_field("entry_heading", want.heading, seen.heading);
         compare_field("entry_count", want.count, seen.count);
         compare_field("queue_empty", want.is_empty, seen.is_empty);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_opcode;
   logic [7:0]             req_x_pos;
   logic [7:0]             req_y_pos;
   logic [31:0]            req_turn_time;
   logic [15:0]            req_tie_order;
   logic [7:0]             req_glyph;
   logic signed [3:0]      req_heading;
   logic                   rsp_valid;
   logic [1:0]             rsp_status;
   logic                   rsp_entry_valid;
   logic [7:0]             rsp_entry_x;
   logic [7:0]             rsp_entry_y;
   logic [31:0]            rsp_entry_turn;
   logic [15:0]            rsp_entry_tie;
   logic [7:0]             rsp_entry_glyph;
   logic signed [3:0]      rsp_entry_heading;
   logic [CNT_W-1:0]       rsp_entry_count;
   logic                   rsp_queue_empty;

   turn_queue_shadow shadow;
   int               stall_cycles = 0;

   two_key_priority_queue_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_x_pos         (req_x_pos),
      .req_y_pos         (req_y_pos),
      .req_turn_time     (req_turn_time),
      .req_tie_order     (req_tie_order),
      .req_glyph         (req_glyph),
      .req_heading       (req_heading),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_entry_x       (rsp_entry_x),
      .rsp_entry_y       (rsp_entry_y),
      .rsp_entry_turn    (rsp_entry_turn),
      .rsp_entry_tie     (rsp_entry_tie),
      .rsp_entry_glyph   (rsp_entry_glyph),
      .rsp_entry_heading (rsp_entry_heading),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_queue_empty   (rsp_queue_empty)
   );

   always #5 clock = ~clock;

   // Sample each result at the edge that ends its cycle.
   always @(posedge clock) begin : watch_results
      reply_type seen;
      if (!reset && rsp_valid) begin
         seen.status   = status_type'(rsp_status);
         seen.valid    = rsp_entry_valid;
         seen.x        = rsp_entry_x;
         seen.y        = rsp_entry_y;
         seen.turn     = rsp_entry_turn;
         seen.tie      = rsp_entry_tie;
         seen.glyph    = rsp_entry_glyph;
         seen.heading  = rsp_entry_heading;
         seen.count    = rsp_entry_count;
         seen.is_empty = rsp_queue_empty;
         shadow.check_reply(seen);
      end
   end

   // Count cycles in which neither an item nor a result moves; end a hung run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("tb_two_key_priority_queue_core: done, errors");
         $finish;
      end
   end

   function automatic entry_type make_entry(logic [31:0] turn, logic [15:0] tie,
                                            logic [7:0] x, logic [7:0] y,
                                            logic [7:0] glyph, logic [3:0] heading);
      entry_type e;
      e.key = {turn, tie};
      e.pay = {heading, glyph, y, x};
      return e;
   endfunction

   // Mix heavy key collisions, extremes, a narrow turn band and fully random keys.
   function automatic entry_type random_entry();
      logic [31:0] turn;
      logic [15:0] tie;
      case ($urandom_range(0, 3))
         0: begin
            turn = $urandom_range(0, 3);
            tie  = 16'($urandom_range(0, 2));
         end
         1: begin
            turn = $urandom;
            tie  = 16'($urandom_range(0, 65535));
         end
         2: begin
            case ($urandom_range(0, 3))
               0: turn = 32'h0000_0000;
               1: turn = 32'hFFFF_FFFF;
               2: turn = 32'h8000_0000;
               default: turn = 32'h7FFF_FFFF;
            endcase
            tie = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         default: begin
            turn = $urandom_range(100, 110);
            tie  = 16'($urandom);
         end
      endcase
      return make_entry(turn, tie, 8'($urandom), 8'($urandom), 8'($urandom),
                        4'($urandom_range(0, 8) - 1));
   endfunction

   // Drive one item at the falling edge and hold it until the core takes it.
   task automatic send_item(input op_type op, input entry_type e, input int idle_pct);
      int gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 20) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode    = op;
      req_turn_time = e.key[47:16];
      req_tie_order = e.key[15:0];
      req_x_pos     = e.pay[7:0];
      req_y_pos     = e.pay[15:8];
      req_glyph     = e.pay[23:16];
      req_heading   = e.pay[27:24];
      start         = 1'b1;
      do @(posedge clock); while (busy);
      shadow.note_command(op, e);
   endtask

   // Drop start and hold off until every owed reply has arrived.
   task automatic wait_for_replies();
      @(negedge clock);
      start = 1'b0;
      while (shadow.pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      // pop on an empty queue
      send_item(OP_POP, random_entry(), 16);
      // largest key with x, y and glyph all ones and heading 7, then smallest key with no heading
      send_item(OP_PUSH, make_entry('1, '1, 8'hFF, 8'hFF, 8'hFF, 4'sd7), 16);
      send_item(OP_PUSH, make_entry('0, '0, 8'h00, 8'h00, 8'h00, 4'hF), 16);
      // equal key: the newer entry must go behind the older one
      send_item(OP_PUSH, make_entry('0, '0, 8'h5A, 8'hA5, 8'h3C, 4'h0), 16);
      send_item(OP_PUSH, make_entry('0, 16'hFFFF, 8'h01, 8'h80, 8'h7F, 4'h3), 16);
      send_item(OP_PUSH, make_entry(32'hFFFF_FFFF, '0, 8'hC3, 8'h3C, 8'h81, 4'h6), 16);
      send_item(OP_PUSH, make_entry(32'h8000_0000, 16'd1, 8'h10, 8'h20, 8'h30, 4'h1), 16);
      send_item(OP_PUSH, make_entry(32'h7FFF_FFFF, 16'hFFFF, 8'h11, 8'h22, 8'h33, 4'h2), 16);
      // same turn time: tie order decides
      send_item(OP_PUSH, make_entry(32'd1000, 16'd5, 8'h40, 8'h41, 8'h42, 4'h4), 16);
      send_item(OP_PUSH, make_entry(32'd1000, 16'd4, 8'h50, 8'h51, 8'h52, 4'h5), 16);
      send_item(OP_PUSH, make_entry(32'd1000, 16'd5, 8'h60, 8'h61, 8'h62, 4'hF), 16);
      while (shadow.fill < QUEUE_DEPTH) send_item(OP_PUSH, random_entry(), 16);
      // full queue: even the smallest key must be dropped
      send_item(OP_PUSH, make_entry('0, '0, 8'hEE, 8'hEE, 8'hEE, 4'h7), 16);
      repeat (3) send_item(OP_POP, random_entry(), 16);
   endtask

   // Random push/pop mix; shift the push bias every span so the queue swings
   // between empty and full.
   task automatic run_random(input int items, input int idle_pct);
      int     n;
      int     push_pct;
      op_type op;
      push_pct = 50;
      for (n = 0; n < items; n++) begin
         if (n % BIAS_SPAN == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
         send_item(op, random_entry(), idle_pct);
      end
   endtask

   initial begin
      shadow        = new();
      reset         = 1'b1;
      start         = 1'b0;
      req_opcode    = 1'b0;
      req_x_pos     = '0;
      req_y_pos     = '0;
      req_turn_time = '0;
      req_tie_order = '0;
      req_glyph     = '0;
      req_heading   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      wait_for_replies();
      // sender idles often, then heavily, then never
      run_random(PHASE_ITEMS, 16);
      wait_for_replies();
      run_random(PHASE_ITEMS, 60);
      wait_for_replies();
      run_random(PHASE_ITEMS, 0);
      wait_for_replies();
      // let a stray result show up before closing
      repeat (QUEUE_DEPTH + 4) @(posedge clock);

      $display("ran %0d pushes (%0d dropped as full) and %0d pops (%0d on empty)",
               shadow.pushes, shadow.full_drops, shadow.pops, shadow.empty_pops);
      $display("deepest fill %0d of %0d, %0d field mismatches",
               shadow.deepest, QUEUE_DEPTH, shadow.mismatches);
      if (shadow.mismatches == 0) begin
         $display("tb_two_key_priority_queue_core: done, clean");
      end else begin
         $display("tb_two_key_priority_queue_core: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/tkpq_pkg.sv
sv/tkpq_ram.sv
sv/tkpq_seq.sv
sv/two_key_priority_queue_core.sv
bench/tb_two_key_priority_queue_core.sv
